/* design/fsa_pkg.sv */
`default_nettype none

package fsa_pkg;

   localparam int WORD_W   = 64;
   localparam int COUNT_W  = 4;
   localparam int OUT_W    = 48;
   localparam int LANES    = 4;
   localparam int LANE_W   = 16;
   localparam int BYTE_W   = 8;
   localparam int SUM_W    = 18;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 1;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_SAMPLE_WIDTH = 1'd0;
   localparam csr_index_type CSR_ALPHA_MASK   = 1'd1;

   // Per-lane control: sample mode plus which parts of the lane count.
   typedef struct packed {
      logic wide;
      logic sample_en;
      logic lo_en;
      logic hi_en;
   } lane_ctl_type;

   typedef logic [LANES-1:0][LANE_W-1:0] lane_diffs_type;

   function automatic lane_ctl_type lane_ctl(input logic wide, input logic alpha,
                                             input logic [COUNT_W-1:0] valid_bytes,
                                             input int lane);
      logic [COUNT_W-1:0] nb;
      logic [COUNT_W-1:0] lo_pos;
      logic [COUNT_W-1:0] hi_pos;
      logic [COUNT_W-1:0] lane_pos;
      lane_ctl_type       ctl;
      nb       = (valid_bytes > COUNT_W'(8)) ? COUNT_W'(8) : valid_bytes;
      lo_pos   = COUNT_W'(2 * lane);
      hi_pos   = COUNT_W'(2 * lane + 1);
      lane_pos = COUNT_W'(lane);
      // keep whole pixels only when alpha is present
      if (alpha) begin
         nb = wide ? (nb & COUNT_W'(8)) : (nb & COUNT_W'(12));
      end
      ctl.wide      = wide;
      ctl.sample_en = (lane_pos < (nb >> 1)) && !(alpha && (lane_pos == COUNT_W'(3)));
      ctl.lo_en     = (lo_pos < nb) && !(alpha && (lo_pos[1:0] == 2'd3));
      ctl.hi_en     = (hi_pos < nb) && !(alpha && (hi_pos[1:0] == 2'd3));
      return ctl;
   endfunction

endpackage

`default_nettype wire

/* design/fsa_lane.sv */
`default_nettype none

module fsa_lane (
   input  wire logic                        clock,
   input  wire logic                        load,
   input  wire fsa_pkg::lane_ctl_type       ctl,
   input  wire logic [fsa_pkg::LANE_W-1:0]  cur,
   input  wire logic [fsa_pkg::LANE_W-1:0]  rfr,
   output logic      [fsa_pkg::LANE_W-1:0]  diff_ff
);
   import fsa_pkg::*;

   logic [LANE_W-1:0] wide_diff;
   logic [BYTE_W-1:0] lo_diff;
   logic [BYTE_W-1:0] hi_diff;
   logic [LANE_W-1:0] diff_in;

   always_comb begin
      wide_diff = (cur > rfr) ? (cur - rfr) : (rfr - cur);
      lo_diff   = (cur[BYTE_W-1:0] > rfr[BYTE_W-1:0])
                  ? (cur[BYTE_W-1:0] - rfr[BYTE_W-1:0])
                  : (rfr[BYTE_W-1:0] - cur[BYTE_W-1:0]);
      hi_diff   = (cur[LANE_W-1:BYTE_W] > rfr[LANE_W-1:BYTE_W])
                  ? (cur[LANE_W-1:BYTE_W] - rfr[LANE_W-1:BYTE_W])
                  : (rfr[LANE_W-1:BYTE_W] - cur[LANE_W-1:BYTE_W]);
      if (ctl.wide) begin
         diff_in = ctl.sample_en ? wide_diff : '0;
      end else begin
         diff_in = (ctl.lo_en ? LANE_W'(lo_diff) : '0) + (ctl.hi_en ? LANE_W'(hi_diff) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         diff_ff <= diff_in;
      end
   end

endmodule

`default_nettype wire

/* design/fsa_merge.sv */
`default_nettype none

module fsa_merge (
   input  wire logic                           clock,
   input  wire logic                           load,
   input  wire fsa_pkg::lane_diffs_type        diffs,
   output logic      [fsa_pkg::SUM_W-1:0]      sum_ff
);
   import fsa_pkg::*;

   logic [SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + SUM_W'(diffs[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff <= sum_in;
      end
   end

endmodule

`default_nettype wire

/* design/frame_sad_accumulator.sv */
`default_nettype none

// Channel | Ports                                              | Transfer when
// --------+----------------------------------------------------+--------------------
// req     | current_word, reference_word, valid_bytes, frame_end | req_valid & req_ready
// rsp     | total_sad                                          | rsp_valid & rsp_ready
// csr     | index, wdata (write only)                          | csr_we
//
// One word per cycle sustained while no frame_end word waits on a stalled rsp side.
// After its last word transfers in, a frame total moves through the lane difference register,
// lane merge register, then output register. Reset sets 8-bit samples, no alpha masking,
// and a zero running total. A stalled rsp side holds only words flagged frame_end; other words
// keep draining into the total, so req stays ready until a second frame_end word waits in
// the merge register while a result still waits and the lane difference register is full.

module frame_sad_accumulator #(
   parameter int TOTAL_WIDTH = 48
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [fsa_pkg::WORD_W-1:0]      req_current_word,
   input  wire logic [fsa_pkg::WORD_W-1:0]      req_reference_word,
   input  wire logic [fsa_pkg::COUNT_W-1:0]     req_valid_bytes,
   input  wire logic                            req_frame_end,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [fsa_pkg::OUT_W-1:0]       rsp_total_sad,
   input  wire logic                            csr_we,
   input  wire fsa_pkg::csr_index_type          csr_index,
   input  wire logic [fsa_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import fsa_pkg::*;

   localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

   logic                       sample_width_ff;
   logic                       alpha_ff;
   logic                       a_valid_ff;
   logic                       a_end_ff;
   logic                       b_valid_ff;
   logic                       b_end_ff;
   logic [TOTAL_WIDTH-1:0]     acc_ff;
   logic [TOTAL_WIDTH-1:0]     acc_in;
   logic [TOTAL_WIDTH:0]       acc_sum;
   logic [OUT_W+TOTAL_WIDTH-1:0] total_ext;
   logic                       rsp_valid_ff;
   logic [OUT_W-1:0]           rsp_total_ff;
   logic [OUT_W-1:0]           rsp_total_in;
   logic                       a_load;
   logic                       a_move;
   logic                       b_ready;
   logic                       b_move;
   lane_diffs_type             lane_diffs;
   logic [SUM_W-1:0]           b_sum_ff;

   // Word sum drains unless it closes a frame and the output register is busy.
   assign b_move    = b_valid_ff && (!b_end_ff || !rsp_valid_ff || rsp_ready);
   assign b_ready   = !b_valid_ff || b_move;
   assign a_move    = a_valid_ff && b_ready;
   assign req_ready = !a_valid_ff || b_ready;
   assign a_load    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_width_ff <= 1'b0;
         alpha_ff        <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAMPLE_WIDTH: sample_width_ff <= csr_wdata[0];
            CSR_ALPHA_MASK:   alpha_ff        <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lane_ctl_type ctl;
      assign ctl = lane_ctl(sample_width_ff, alpha_ff, req_valid_bytes, i);
      fsa_lane u_lane (
         .clock   (clock),
         .load    (a_load),
         .ctl     (ctl),
         .cur     (req_current_word[i*LANE_W +: LANE_W]),
         .rfr     (req_reference_word[i*LANE_W +: LANE_W]),
         .diff_ff (lane_diffs[i])
      );
   end

   fsa_merge u_merge (
      .clock  (clock),
      .load   (a_move),
      .diffs  (lane_diffs),
      .sum_ff (b_sum_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            a_valid_ff <= req_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_end_ff <= req_frame_end;
      end
      if (a_move) begin
         b_end_ff <= a_end_ff;
      end
   end

   // Saturating accumulate; a carry out of the top means the total pegs.
   always_comb begin
      acc_sum      = {1'b0, acc_ff} + (TOTAL_WIDTH+1)'(b_sum_ff);
      acc_in       = acc_sum[TOTAL_WIDTH] ? TOTAL_MAX : acc_sum[TOTAL_WIDTH-1:0];
      total_ext    = {{OUT_W{1'b0}}, acc_in};
      rsp_total_in = total_ext[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (b_move) begin
            acc_ff <= b_end_ff ? '0 : acc_in;
         end
         if (b_move && b_end_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_move && b_end_ff) begin
         rsp_total_ff <= rsp_total_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_total_sad = rsp_total_ff;

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      b_move && b_end_ff |=> acc_ff == '0)
      else $error("running total not cleared after frame end");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      b_move && b_end_ff |-> (!rsp_valid_ff || rsp_ready))
      else $error("frame total overwrote a pending result");

   a_saturation_sticks: assert property (@(posedge clock) disable iff (reset)
      (acc_ff == TOTAL_MAX) && !(b_move && b_end_ff) |=> acc_ff == TOTAL_MAX)
      else $error("saturated total left the top of range without a clear");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_move |=> b_valid_ff && $stable(b_sum_ff) && $stable(acc_ff))
      else $error("stalled word sum changed or was lost");

endmodule

`default_nettype wire

/* test/tb_frame_sad_accumulator.sv */
module tb_frame_sad_accumulator;
   import fsa_pkg::*;

   localparam int TOTAL_W     = 48;
   localparam int PIPE_DEPTH  = 3;
   localparam int PHASE_WORDS = 112;
   localparam int MAX_SHOWN   = 10;

   localparam logic [WORD_W-1:0] FULL      = {WORD_W{1'b1}};
   localparam logic [63:0]       TOTAL_MAX = {64{1'b1}} >> (64 - TOTAL_W);

   typedef struct packed {
      logic               wide;
      logic               alpha;
      logic [WORD_W-1:0]  cur;
      logic [WORD_W-1:0]  oth;
      logic [COUNT_W-1:0] nbytes;
      logic               last;
      logic               typed;
      logic [OUT_W-1:0]   total;
   } sad_vector_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_ready;
   logic [WORD_W-1:0]   req_current_word   = '0;
   logic [WORD_W-1:0]   req_reference_word = '0;
   logic [COUNT_W-1:0]  req_valid_bytes    = '0;
   logic                req_frame_end      = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready          = 1'b0;
   logic [OUT_W-1:0]    rsp_total_sad;
   logic                csr_we             = 1'b0;
   csr_index_type       csr_index          = CSR_SAMPLE_WIDTH;
   logic [CSR_DAT_W-1:0] csr_wdata         = '0;

   sad_vector_type   vectors[$];
   logic [OUT_W-1:0] frame_totals_q[$];
   logic             wide_cfg      = 1'b0;
   logic             alpha_cfg     = 1'b0;
   logic [63:0]      frame_total   = '0;
   int               send_idle_pct = 30;
   int               recv_idle_pct = 48;
   int               fail_count    = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   frame_sad_accumulator #(
      .TOTAL_WIDTH(TOTAL_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_current_word   (req_current_word),
      .req_reference_word (req_reference_word),
      .req_valid_bytes    (req_valid_bytes),
      .req_frame_end      (req_frame_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_total_sad      (rsp_total_sad),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Sum of absolute differences of one word pair under the current settings.
   function automatic int word_sad(input logic [WORD_W-1:0] cur,
                                   input logic [WORD_W-1:0] oth,
                                   input logic [COUNT_W-1:0] nbytes);
      int nb;
      int acc;
      int a;
      int b;
      nb = (nbytes > 8) ? 8 : int'(nbytes);
      // only whole pixels count when alpha is present
      if (alpha_cfg) begin
         nb = wide_cfg ? (nb & 8) : (nb & 12);
      end
      acc = 0;
      if (wide_cfg) begin
         for (int i = 0; i < nb / 2; i++) begin
            if (!(alpha_cfg && i == 3)) begin
               a = int'(cur[16*i +: 16]);
               b = int'(oth[16*i +: 16]);
               acc += (a > b) ? a - b : b - a;
            end
         end
      end else begin
         for (int i = 0; i < nb; i++) begin
            if (!(alpha_cfg && (i % 4) == 3)) begin
               a = int'(cur[8*i +: 8]);
               b = int'(oth[8*i +: 8]);
               acc += (a > b) ? a - b : b - a;
            end
         end
      end
      return acc;
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return FULL;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_row(input logic wide, input logic alpha,
                          input logic [WORD_W-1:0] cur, input logic [WORD_W-1:0] oth,
                          input logic [COUNT_W-1:0] nbytes, input logic last,
                          input logic typed, input logic [OUT_W-1:0] total);
      sad_vector_type row;
      row.wide   = wide;
      row.alpha  = alpha;
      row.cur    = cur;
      row.oth    = oth;
      row.nbytes = nbytes;
      row.last   = last;
      row.typed  = typed;
      row.total  = total;
      vectors.push_back(row);
   endtask

   // Start on the edge that took the previous word; return on the edge that takes this one.
   task automatic send_word(input logic [WORD_W-1:0] cur, input logic [WORD_W-1:0] oth,
                            input logic [COUNT_W-1:0] nbytes, input logic last,
                            input logic typed, input logic [OUT_W-1:0] typed_total);
      logic [63:0] sad;
      logic        taken;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_current_word   <= cur;
      req_reference_word <= oth;
      req_valid_bytes    <= nbytes;
      req_frame_end      <= last;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_ready;
      end
      sad = 64'(word_sad(cur, oth, nbytes));
      if (frame_total > TOTAL_MAX - sad) begin
         frame_total = TOTAL_MAX;
      end else begin
         frame_total = frame_total + sad;
      end
      if (last) begin
         frame_totals_q.push_back(typed ? typed_total : frame_total[OUT_W-1:0]);
         frame_total = '0;
      end
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (frame_totals_q.size() != 0) @(posedge clock);
      // words without frame_end may still be on their way into the total
      repeat (PIPE_DEPTH + 3) @(posedge clock);
   endtask

   task automatic set_config(input logic wide, input logic alpha);
      csr_we    <= 1'b1;
      csr_index <= CSR_SAMPLE_WIDTH;
      csr_wdata <= wide;
      @(posedge clock);
      csr_index <= CSR_ALPHA_MASK;
      csr_wdata <= alpha;
      @(posedge clock);
      csr_we    <= 1'b0;
      wide_cfg  = wide;
      alpha_cfg = alpha;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (frame_totals_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_SHOWN)
                  $display("unexpected frame total transfer: got %0d", rsp_total_sad);
            end else begin
               if (rsp_total_sad !== frame_totals_q[0]) begin
                  fail_count++;
                  if (fail_count <= MAX_SHOWN)
                     $display("frame total mismatch: expected %0d, got %0d",
                              frame_totals_q[0], rsp_total_sad);
               end
               void'(frame_totals_q.pop_front());
            end
         end
      end
   end

   initial begin
      sad_vector_type    row;
      logic [WORD_W-1:0] cur;
      logic [WORD_W-1:0] oth;
      logic [COUNT_W-1:0] nbytes;
      int                words;
      int                frame_len;
      int                setting;

      // 8-bit samples, no alpha
      add_row(0, 0, FULL, '0, 8, 1, 1, 48'd2040);
      add_row(0, 0, '0, FULL, 8, 1, 1, 48'd2040);
      add_row(0, 0, FULL, '0, 0, 1, 1, 48'd0);
      add_row(0, 0, FULL, '0, 15, 1, 1, 48'd2040);
      add_row(0, 0, FULL, '0, 3, 0, 0, '0);
      add_row(0, 0, 64'h10, 64'h01, 1, 1, 1, 48'd780);
      add_row(0, 0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 8, 0, 0, '0);
      add_row(0, 0, 64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 5, 1, 0, '0);
      // 16-bit samples, no alpha
      add_row(1, 0, FULL, '0, 8, 1, 1, 48'd262140);
      add_row(1, 0, FULL, '0, 7, 1, 1, 48'd196605);
      add_row(1, 0, FULL, '0, 1, 1, 1, 48'd0);
      add_row(1, 0, FULL, '0, 9, 1, 1, 48'd262140);
      add_row(1, 0, 64'h1, FULL, 2, 1, 1, 48'd65534);
      add_row(1, 0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 6, 1, 0, '0);
      // 8-bit samples, alpha masked
      add_row(0, 1, FULL, '0, 8, 1, 1, 48'd1530);
      add_row(0, 1, FULL, '0, 7, 1, 1, 48'd765);
      add_row(0, 1, FULL, '0, 3, 1, 1, 48'd0);
      add_row(0, 1, FULL, '0, 12, 1, 1, 48'd1530);
      add_row(0, 1, 64'hFF00_0000_FF00_0000, '0, 8, 1, 1, 48'd0);
      // 16-bit samples, alpha masked, then 8-bit samples with no alpha
      add_row(1, 1, FULL, '0, 8, 1, 1, 48'd196605);
      add_row(1, 1, FULL, '0, 7, 1, 1, 48'd0);
      add_row(1, 1, FULL, '0, 15, 1, 1, 48'd196605);
      add_row(1, 1, 64'hFFFF_0000_0000_0000, '0, 8, 1, 1, 48'd0);
      add_row(0, 0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 4, 0, 0, '0);
      add_row(0, 0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 8, 1, 0, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[k]) begin
         row = vectors[k];
         if (row.wide != wide_cfg || row.alpha != alpha_cfg) begin
            quiesce();
            set_config(row.wide, row.alpha);
         end
         send_word(row.cur, row.oth, row.nbytes, row.last, row.typed, row.total);
      end

      for (int pass = 0; pass < 3; pass++) begin
         case (pass)
            0: begin
               send_idle_pct = 30;
               recv_idle_pct = 48;
            end
            1: begin
               send_idle_pct = 48;
               recv_idle_pct = 30;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int k = 0; k < 4; k++) begin
            setting = (k + pass) % 4;
            quiesce();
            set_config(setting[0], setting[1]);
            words = 0;
            while (words < PHASE_WORDS) begin
               frame_len = $urandom_range(1, 12);
               for (int j = 0; j < frame_len; j++) begin
                  cur = random_word();
                  case ($urandom_range(0, 7))
                     0:       oth = ~cur;
                     1:       oth = cur;
                     2:       oth = cur ^ ({$urandom, $urandom} & 64'h0303_0303_0303_0303);
                     3:       oth = '0;
                     4:       oth = FULL;
                     default: oth = random_word();
                  endcase
                  nbytes = ($urandom_range(0, 9) < 7) ? 4'd8 : 4'($urandom_range(0, 15));
                  send_word(cur, oth, nbytes, j == frame_len - 1, 1'b0, '0);
               end
               words += frame_len;
            end
         end
      end

      quiesce();
      repeat (PIPE_DEPTH) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
